// ----- hw/rtl/arlt_pkg.sv -----
// ----------------------------------------------------------------------------
// Angular range lock table package
// Shared types, command and status codes, and the range coverage test.
// ----------------------------------------------------------------------------
`default_nettype none

package arlt_pkg;

    localparam int ARLT_TABLE_DEPTH = 16;

    localparam logic [9:0] FULL_TURN = 10'd360;
    localparam logic [8:0] HALF_TURN = 9'd180;

    localparam logic [2:0] CMD_SET_ANGLE = 3'd0;
    localparam logic [2:0] CMD_LOCK_RD   = 3'd1;
    localparam logic [2:0] CMD_LOCK_WR   = 3'd2;
    localparam logic [2:0] CMD_UNLOCK_RD = 3'd3;
    localparam logic [2:0] CMD_UNLOCK_WR = 3'd4;
    localparam logic [2:0] CMD_DROP      = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_GRANT = 1'b1;

    typedef struct packed {
        logic        write;
        logic [8:0]  start;
        logic [8:0]  stop;
        logic [15:0] owner;
    } entry_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [15:0] owner;
        logic        write;
        logic        last;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic sc_rd_en;
        logic sc_wr_en;
    } mem_ctl_t;

    function automatic logic covers(input entry_t e, input logic [8:0] a);
        logic hit;
        hit = 1'b0;
        if (e.start < e.stop) begin
            hit = (e.start <= a) && (a <= e.stop);
        end else if (e.start > e.stop) begin
            hit = (a >= e.start) || (a <= e.stop);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/arlt_store.sv -----
// ----------------------------------------------------------------------------
// Angular range lock table storage
// The lock table memory and the scratch memory used to reorder waiters,
// both with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module arlt_store
    import arlt_pkg::*;
#(
    parameter int TABLE_DEPTH = ARLT_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic          aclk,
    input  wire mem_ctl_t      ctl,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    output entry_t             rd_data,
    input  wire logic [AW-1:0] sc_rd_addr,
    input  wire logic [AW-1:0] sc_wr_addr,
    input  wire entry_t        sc_wr_data,
    output entry_t             sc_rd_data
);

    entry_t table_mem [TABLE_DEPTH];
    entry_t scratch_mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sc_wr_en) begin
            scratch_mem[sc_wr_addr] <= sc_wr_data;
        end
        if (ctl.sc_rd_en) begin
            sc_rd_data <= scratch_mem[sc_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/arlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Angular range lock table sequencer
// Decodes a request, searches and compacts the table, rescans the waiters
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module arlt_ctrl
    import arlt_pkg::*;
#(
    parameter int TABLE_DEPTH = ARLT_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_cmd,
    input  wire logic [8:0]    s_degree,
    input  wire logic [7:0]    s_half_width,
    input  wire logic [15:0]   s_owner,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_kind,
    output logic [1:0]         m_status,
    output logic [15:0]        m_granted_owner,
    output logic               m_granted_write,
    output logic               m_last,
    output mem_ctl_t           ctl,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr,
    output entry_t             wr_data,
    input  wire entry_t        rd_data,
    output logic [AW-1:0]      sc_rd_addr,
    output logic [AW-1:0]      sc_wr_addr,
    output entry_t             sc_wr_data,
    input  wire entry_t        sc_rd_data
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_FIND_RD  = 10'b0000000010,
        S_FIND_CHK = 10'b0000000100,
        S_SHIFT_RD = 10'b0000001000,
        S_SHIFT_WR = 10'b0000010000,
        S_SCAN_RD  = 10'b0000100000,
        S_SCAN_CHK = 10'b0001000000,
        S_COPY_RD  = 10'b0010000000,
        S_COPY_WR  = 10'b0100000000,
        S_FLUSH    = 10'b1000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [8:0]    angle_reg, angle_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] wait_reg, wait_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] gcnt_reg, gcnt_next;
    logic [CW-1:0] wcnt_reg, wcnt_next;
    logic [CW-1:0] rm_reg, rm_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [8:0]    st_reg, st_next;
    logic [8:0]    ed_reg, ed_next;
    logic [15:0]   own_reg, own_next;
    logic          cov_reg, cov_next;
    logic          covw_reg, covw_next;
    result_t       pend_reg, pend_next;
    result_t       out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    logic [CW-1:0] total;
    logic [CW-1:0] find_lim;
    logic [CW:0]   grant_pos;
    logic [CW:0]   copy_pos;
    logic          out_free;
    logic          args_ok;
    logic [9:0]    deg_w;
    logic [9:0]    hw_w;
    logic [9:0]    sum_w;
    logic [8:0]    st_calc;
    logic [8:0]    ed_calc;
    logic          hit;
    logic          grant;
    logic          match;

    assign total     = held_reg + wait_reg;
    assign find_lim  = (cmd_reg == CMD_DROP) ? total : held_reg;
    assign grant_pos = {1'b0, held_reg} + {1'b0, gcnt_reg};
    assign copy_pos  = grant_pos + {1'b0, idx_reg};
    assign out_free  = !m_valid_reg || m_ready;

    assign deg_w   = {1'b0, s_degree};
    assign hw_w    = {2'b00, s_half_width};
    assign sum_w   = deg_w + hw_w;
    assign args_ok = (deg_w < FULL_TURN) && (s_half_width != 8'd0)
                     && ({1'b0, s_half_width} < HALF_TURN);
    assign st_calc = (deg_w >= hw_w) ? 9'(deg_w - hw_w) : 9'(deg_w + FULL_TURN - hw_w);
    assign ed_calc = (sum_w >= FULL_TURN) ? 9'(sum_w - FULL_TURN) : 9'(sum_w);

    assign hit   = covers(rd_data, angle_reg);
    assign grant = hit && !(rd_data.write ? cov_reg : covw_reg);
    assign match = (cmd_reg == CMD_DROP) ? (rd_data.owner == own_reg)
                 : (rd_data.start == st_reg) && (rd_data.stop == ed_reg)
                   && (rd_data.write == (cmd_reg == CMD_UNLOCK_WR));

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_status        = out_reg.status;
    assign m_granted_owner = out_reg.owner;
    assign m_granted_write = out_reg.write;
    assign m_last          = out_reg.last;

    always_comb begin
        state_next   = state_reg;
        angle_next   = angle_reg;
        held_next    = held_reg;
        wait_next    = wait_reg;
        idx_next     = idx_reg;
        gcnt_next    = gcnt_reg;
        wcnt_next    = wcnt_reg;
        rm_next      = rm_reg;
        cmd_next     = cmd_reg;
        st_next      = st_reg;
        ed_next      = ed_reg;
        own_next     = own_reg;
        cov_next     = cov_reg;
        covw_next    = covw_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctl          = '0;
        rd_addr      = idx_reg[AW-1:0];
        wr_addr      = total[AW-1:0];
        wr_data      = rd_data;
        sc_rd_addr   = idx_reg[AW-1:0];
        sc_wr_addr   = wcnt_reg[AW-1:0];
        sc_wr_data   = rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    st_next    = st_calc;
                    ed_next    = ed_calc;
                    own_next   = s_owner;
                    idx_next   = '0;
                    gcnt_next  = '0;
                    wcnt_next  = '0;
                    cov_next   = 1'b0;
                    covw_next  = 1'b0;
                    pend_next  = '{kind: KIND_DONE, status: ST_OK, owner: 16'd0,
                                   write: 1'b0, last: 1'b0};
                    state_next = S_SCAN_RD;
                    case (s_cmd) inside
                        CMD_SET_ANGLE: begin
                            if (deg_w < FULL_TURN) begin
                                angle_next = s_degree;
                            end else begin
                                pend_next.status = ST_BAD_ARG;
                            end
                        end
                        CMD_LOCK_RD, CMD_LOCK_WR: begin
                            if (!args_ok) begin
                                pend_next.status = ST_BAD_ARG;
                            end else if (total >= CW'(TABLE_DEPTH)) begin
                                pend_next.status = ST_FULL;
                            end else begin
                                ctl.wr_en = 1'b1;
                                wr_data   = '{write: (s_cmd == CMD_LOCK_WR),
                                              start: st_calc, stop: ed_calc,
                                              owner: s_owner};
                                wait_next = wait_reg + 1'b1;
                            end
                        end
                        CMD_UNLOCK_RD, CMD_UNLOCK_WR: begin
                            if (!args_ok) begin
                                pend_next.status = ST_BAD_ARG;
                            end else begin
                                pend_next.status = ST_NOT_FOUND;
                                state_next       = S_FIND_RD;
                            end
                        end
                        CMD_DROP: begin
                            pend_next.status = ST_NOT_FOUND;
                            state_next       = S_FIND_RD;
                        end
                        default: begin
                            pend_next.status = ST_BAD_ARG;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                if (idx_reg >= find_lim) begin
                    idx_next   = '0;
                    state_next = S_SCAN_RD;
                end else begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                idx_next = idx_reg + 1'b1;
                if (match) begin
                    pend_next.status = ST_OK;
                    rm_next          = idx_reg;
                    state_next       = S_SHIFT_RD;
                end else begin
                    state_next = S_FIND_RD;
                end
            end
            S_SHIFT_RD: begin
                if (idx_reg >= total) begin
                    if (rm_reg < held_reg) begin
                        held_next = held_reg - 1'b1;
                    end else begin
                        wait_next = wait_reg - 1'b1;
                    end
                    idx_next   = '0;
                    state_next = S_SCAN_RD;
                end else begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ctl.wr_en  = 1'b1;
                wr_addr    = AW'(idx_reg - 1'b1);
                idx_next   = idx_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_SCAN_RD: begin
                if (idx_reg >= total) begin
                    idx_next   = '0;
                    state_next = S_COPY_RD;
                end else begin
                    ctl.rd_en  = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (idx_reg < held_reg) begin
                    cov_next   = cov_reg || hit;
                    covw_next  = covw_reg || (hit && rd_data.write);
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end else if (grant) begin
                    if (out_free) begin
                        out_next     = pend_reg;
                        m_valid_next = 1'b1;
                        pend_next    = '{kind: KIND_GRANT, status: ST_OK,
                                         owner: rd_data.owner, write: rd_data.write,
                                         last: 1'b0};
                        ctl.wr_en    = 1'b1;
                        wr_addr      = grant_pos[AW-1:0];
                        gcnt_next    = gcnt_reg + 1'b1;
                        cov_next     = 1'b1;
                        covw_next    = covw_reg || rd_data.write;
                        idx_next     = idx_reg + 1'b1;
                        state_next   = S_SCAN_RD;
                    end
                end else begin
                    ctl.sc_wr_en = 1'b1;
                    wcnt_next    = wcnt_reg + 1'b1;
                    cov_next     = cov_reg || hit;
                    covw_next    = covw_reg || (hit && rd_data.write);
                    idx_next     = idx_reg + 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_COPY_RD: begin
                if ((idx_reg >= wcnt_reg) || (gcnt_reg == '0)) begin
                    state_next = S_FLUSH;
                end else begin
                    ctl.sc_rd_en = 1'b1;
                    state_next   = S_COPY_WR;
                end
            end
            S_COPY_WR: begin
                ctl.wr_en  = 1'b1;
                wr_addr    = copy_pos[AW-1:0];
                wr_data    = sc_rd_data;
                idx_next   = idx_reg + 1'b1;
                state_next = S_COPY_RD;
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    m_valid_next  = 1'b1;
                    held_next     = held_reg + gcnt_reg;
                    wait_next     = wait_reg - gcnt_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            angle_reg   <= '0;
            held_reg    <= '0;
            wait_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            angle_reg   <= angle_next;
            held_reg    <= held_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        gcnt_reg <= gcnt_next;
        wcnt_reg <= wcnt_next;
        rm_reg   <= rm_next;
        cmd_reg  <= cmd_next;
        st_reg   <= st_next;
        ed_reg   <= ed_next;
        own_reg  <= own_next;
        cov_reg  <= cov_next;
        covw_reg <= covw_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/angular_range_rw_lock_table_unit.sv -----
// ----------------------------------------------------------------------------
// Angular range reader-writer lock table
// Keeps a current angle and a table of read and write locks over circular
// degree ranges, granting waiting locks whose range covers the angle without conflict.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (cmd, degree, half_width, owner) and
// results leave on the m_ channel, both with valid and ready. Each request
// gives one completion result followed by one grant notice for every waiter
// granted in the rescan; m_last marks the final result of a request.
// A request is taken only while the sequencer is idle. Each table step is
// a read state followed by a check or write state: an optional search and
// compaction pass, a rescan over the N stored entries, and, when a grant
// reorders the waiters, a copy from the scratch memory of the W waiters
// left. The completion leaves as soon as the rescan knows whether it is
// the last result.
// Reset empties the table and sets the angle to zero; no clearing pass is
// needed. When the receiver stalls, the rescan holds at the next grant and
// the request in flight waits until the result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module angular_range_rw_lock_table_unit
    import arlt_pkg::*;
#(
    parameter int TABLE_DEPTH = ARLT_TABLE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [8:0]  s_degree,
    input  wire logic [7:0]  s_half_width,
    input  wire logic [15:0] s_owner,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [1:0]       m_status,
    output logic [15:0]      m_granted_owner,
    output logic             m_granted_write,
    output logic             m_last
);

    localparam int AW = $clog2(TABLE_DEPTH);

    mem_ctl_t      ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;
    logic [AW-1:0] sc_rd_addr;
    logic [AW-1:0] sc_wr_addr;
    entry_t        sc_wr_data;
    entry_t        sc_rd_data;

    arlt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_degree        (s_degree),
        .s_half_width    (s_half_width),
        .s_owner         (s_owner),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_status        (m_status),
        .m_granted_owner (m_granted_owner),
        .m_granted_write (m_granted_write),
        .m_last          (m_last),
        .ctl             (ctl),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_data         (rd_data),
        .sc_rd_addr      (sc_rd_addr),
        .sc_wr_addr      (sc_wr_addr),
        .sc_wr_data      (sc_wr_data),
        .sc_rd_data      (sc_rd_data)
    );

    arlt_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk       (aclk),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_data    (rd_data),
        .sc_rd_addr (sc_rd_addr),
        .sc_wr_addr (sc_wr_addr),
        .sc_wr_data (sc_wr_data),
        .sc_rd_data (sc_rd_data)
    );

endmodule

`default_nettype wire
